// File: hw/rtl/lwam_pkg.sv
// Package for the latency window anomaly monitor.
// Widths, register reset values, register indexes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lwam_pkg;

    localparam int LATENCY_BITS = 32;
    localparam int SUM_BITS     = 48;

    localparam int LAT_IN_W  = 32;
    localparam int TIME_W    = 40;
    localparam int CNT_W     = 16;
    localparam int THR_W     = 16;
    localparam int WNUM_W    = 20;
    localparam int BASE_W    = 32;
    localparam int MEAN_W    = 32;

    localparam int LAT_USE_W = (LATENCY_BITS < LAT_IN_W) ? LATENCY_BITS : LAT_IN_W;
    localparam int PROD_W    = THR_W + BASE_W;
    localparam int NB_W      = WNUM_W + BASE_W;
    localparam int DIVD_W    = (SUM_BITS > NB_W + 1) ? SUM_BITS : NB_W + 1;
    localparam int DIVS_W    = (WNUM_W > CNT_W) ? WNUM_W : CNT_W;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [CNT_W-1:0]  WSIZE_RESET   = 16'd1024;
    localparam logic [THR_W-1:0]  THR_RESET     = 16'd512;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 40'd5000000000;

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_TIMEOUT     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0]  window_size;
        logic [THR_W-1:0]  threshold;
        logic [TIME_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic accum;
        logic div_load_mean;
        logic div_step;
        logic store_mean;
        logic mult;
        logic check;
        logic store_base;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic div_last;
        logic alert;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/lwam_regs.sv
// Configuration register file of the latency window anomaly monitor, APB-style port.
// Depends on lwam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwam_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lwam_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lwam_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lwam_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output lwam_pkg::t_cfg                        o_cfg
);

    lwam_pkg::t_cfg     r_cfg;
    lwam_pkg::t_reg_idx idx;

    assign idx    = lwam_pkg::t_reg_idx'(paddr[4:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size <= lwam_pkg::WSIZE_RESET;
            r_cfg.threshold   <= lwam_pkg::THR_RESET;
            r_cfg.timeout     <= lwam_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                lwam_pkg::REG_WINDOW_SIZE: begin
                    r_cfg.window_size <= pwdata[lwam_pkg::CNT_W-1:0];
                end
                lwam_pkg::REG_THRESHOLD: begin
                    r_cfg.threshold <= pwdata[lwam_pkg::THR_W-1:0];
                end
                lwam_pkg::REG_TIMEOUT: begin
                    r_cfg.timeout <= pwdata[lwam_pkg::TIME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lwam_pkg::REG_WINDOW_SIZE: prdata = lwam_pkg::APB_DATA_W'(r_cfg.window_size);
            lwam_pkg::REG_THRESHOLD:   prdata = lwam_pkg::APB_DATA_W'(r_cfg.threshold);
            lwam_pkg::REG_TIMEOUT:     prdata = lwam_pkg::APB_DATA_W'(r_cfg.timeout);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lwam_ctrl.sv
// Controller of the latency window anomaly monitor: one-hot sequencer and output valid.
// Depends on lwam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwam_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    input  wire lwam_pkg::t_status i_status,
    output lwam_pkg::t_cmd         o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_ACCUM    = 10'b00_0000_0010,
        S_DECIDE   = 10'b00_0000_0100,
        S_DIV_MEAN = 10'b00_0000_1000,
        S_MEAN     = 10'b00_0001_0000,
        S_MULT     = 10'b00_0010_0000,
        S_CHECK    = 10'b00_0100_0000,
        S_DIV_BASE = 10'b00_1000_0000,
        S_BASE     = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.close) begin
                    o_cmd.div_load_mean = 1'b1;
                    n_state             = S_DIV_MEAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_MEAN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.store_mean = 1'b1;
                n_state          = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.alert ? S_OUT : S_DIV_BASE;
            end
            S_DIV_BASE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.store_base = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.load_out) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lwam_dpath.sv
// Datapath of the latency window anomaly monitor: window state, serial divider,
// multipliers and output register. Depends on lwam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lwam_dpath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lwam_pkg::t_cmd                   i_cmd,
    output lwam_pkg::t_status                     o_status,
    input  wire lwam_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_command,
    input  wire logic [lwam_pkg::LAT_IN_W-1:0]    i_latency,
    input  wire logic [lwam_pkg::TIME_W-1:0]      i_now,
    output logic                                  o_closed,
    output logic                                  o_alert,
    output logic      [lwam_pkg::MEAN_W-1:0]      o_mean,
    output logic      [lwam_pkg::BASE_W-1:0]      o_baseline,
    output logic      [lwam_pkg::CNT_W-1:0]       o_count
);

    localparam int SUM_BITS  = lwam_pkg::SUM_BITS;
    localparam int LAT_USE_W = lwam_pkg::LAT_USE_W;
    localparam int TIME_W    = lwam_pkg::TIME_W;
    localparam int CNT_W     = lwam_pkg::CNT_W;
    localparam int WNUM_W    = lwam_pkg::WNUM_W;
    localparam int BASE_W    = lwam_pkg::BASE_W;
    localparam int MEAN_W    = lwam_pkg::MEAN_W;
    localparam int PROD_W    = lwam_pkg::PROD_W;
    localparam int NB_W      = lwam_pkg::NB_W;
    localparam int DIVD_W    = lwam_pkg::DIVD_W;
    localparam int DIVS_W    = lwam_pkg::DIVS_W;
    localparam int DCNT_W    = lwam_pkg::DCNT_W;

    // window state
    logic [SUM_BITS-1:0] r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [WNUM_W-1:0]   r_wnum;
    logic [BASE_W-1:0]   r_base;
    logic [TIME_W-1:0]   r_last;
    logic                r_checked;
    logic                r_close;

    // item and intermediate values
    logic                r_command;
    logic [LAT_USE_W-1:0] r_lat;
    logic [TIME_W-1:0]   r_now;
    logic [MEAN_W-1:0]   r_mean;
    logic                r_alert;
    logic [PROD_W-1:0]   r_prod;
    logic [NB_W-1:0]     r_nb;

    // serial divider
    logic [DIVD_W-1:0]   r_quo;
    logic [DIVS_W-1:0]   r_rem;
    logic [DIVS_W-1:0]   r_dsor;
    logic [DCNT_W-1:0]   r_dcnt;

    // output register
    logic                r_o_closed;
    logic                r_o_alert;
    logic [MEAN_W-1:0]   r_o_mean;
    logic [BASE_W-1:0]   r_o_base;
    logic [CNT_W-1:0]    r_o_count;

    logic [SUM_BITS:0]   sum_ext;
    logic [SUM_BITS-1:0] sum_new;
    logic [CNT_W-1:0]    cnt_new;
    logic [TIME_W-1:0]   elapsed;
    logic                timed_out;
    logic                close_now;
    logic [WNUM_W-1:0]   n_eff;
    logic                alert_now;
    logic [MEAN_W-1:0]   mean_sat;
    logic [DIVD_W-1:0]   base_dividend;
    logic [DIVS_W:0]     rem_sh;
    logic                div_ge;
    logic [DIVS_W:0]     rem_sub;

    assign sum_ext   = {1'b0, r_sum} + (SUM_BITS + 1)'(r_lat);
    assign sum_new   = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
    assign cnt_new   = (r_count == {CNT_W{1'b1}}) ? r_count : r_count + 1'b1;
    assign elapsed   = r_now - r_last;
    assign timed_out = r_checked && (r_now >= r_last) && (elapsed > i_cfg.timeout);
    assign close_now = !r_command && ((cnt_new >= i_cfg.window_size) || timed_out);

    assign n_eff     = (r_wnum == '0) ? WNUM_W'(1) : r_wnum;
    assign alert_now = ((PROD_W'(r_mean) << 8) > r_prod) && (r_wnum > WNUM_W'(2));
    assign mean_sat  = (|r_quo[DIVD_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : r_quo[MEAN_W-1:0];
    assign base_dividend = DIVD_W'(r_nb) + DIVD_W'(r_mean);

    assign rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_dsor});
    assign rem_sub = rem_sh - {1'b0, r_dsor};

    assign o_status.close    = r_close;
    assign o_status.div_last = (r_dcnt == DCNT_W'(1));
    assign o_status.alert    = alert_now;

    assign o_closed   = r_o_closed;
    assign o_alert    = r_o_alert;
    assign o_mean     = r_o_mean;
    assign o_baseline = r_o_base;
    assign o_count    = r_o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_wnum    <= WNUM_W'(1);
            r_base    <= '0;
            r_last    <= '0;
            r_checked <= 1'b0;
            r_close   <= 1'b0;
        end else begin
            if (i_cmd.accum) begin
                r_close <= close_now;
                if (r_command) begin
                    r_sum   <= '0;
                    r_count <= '0;
                    r_wnum  <= WNUM_W'(1);
                    r_base  <= '0;
                end else begin
                    r_sum   <= sum_new;
                    r_count <= cnt_new;
                end
            end
            if (i_cmd.check) begin
                r_last    <= r_now;
                r_checked <= 1'b1;
                r_sum     <= '0;
                r_count   <= '0;
            end
            if (i_cmd.store_base) begin
                r_base <= r_quo[BASE_W-1:0];
                if (r_wnum != {WNUM_W{1'b1}}) begin
                    r_wnum <= r_wnum + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command <= i_command;
            r_lat     <= i_latency[LAT_USE_W-1:0];
            r_now     <= i_now;
            r_mean    <= '0;
            r_alert   <= 1'b0;
        end
        if (i_cmd.div_load_mean) begin
            r_quo  <= DIVD_W'(r_sum);
            r_rem  <= '0;
            r_dsor <= DIVS_W'(r_count);
            r_dcnt <= DCNT_W'(DIVD_W);
        end
        if (i_cmd.div_step) begin
            r_quo  <= {r_quo[DIVD_W-2:0], div_ge};
            r_rem  <= div_ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.store_mean) begin
            r_mean <= mean_sat;
        end
        if (i_cmd.mult) begin
            r_prod <= i_cfg.threshold * r_base;
            r_nb   <= (n_eff - 1'b1) * r_base;
        end
        if (i_cmd.check) begin
            r_alert <= alert_now;
            r_quo   <= base_dividend;
            r_rem   <= '0;
            r_dsor  <= DIVS_W'(n_eff);
            r_dcnt  <= DCNT_W'(DIVD_W);
        end
        if (i_cmd.load_out) begin
            r_o_closed <= r_close;
            r_o_alert  <= r_alert;
            r_o_mean   <= r_mean;
            r_o_base   <= r_base;
            r_o_count  <= r_count;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/latency_window_anomaly_monitor.sv
// Top level of the latency window anomaly monitor.
// Instantiates lwam_regs, lwam_ctrl and lwam_dpath; depends on lwam_pkg.
//
// Usage:
//   Slave stream: one transfer per event. s_tuser[0] is the command (0 packet,
//   1 clear counters); s_tdata carries latency and current time in ns.
//   Master stream: exactly one result transfer per input transfer, in order:
//   window-closed and alert flags in m_tuser, mean, baseline and packet count
//   in m_tdata.
//   APB port: window size, threshold (Q8.8) and timeout at byte addresses 0, 8
//   and 16; write only while the block is idle. pready is always high.
//   Sequence: a clear or a packet that closes no window goes from accumulate
//   and decide straight to the output register. A close runs the shared
//   restoring divider, one bit a cycle, on the mean, then multiplies and
//   checks; a close that alerts then goes to output, and one that folds the
//   mean into the baseline runs the divider again on the baseline before output.
//   Throughput: one item at a time; s_tready is high only between items, so the
//   next transfer is taken no earlier than the cycle after the result is loaded.
//   Reset: synchronous, active low; registers go to their defaults, window
//   state clears, window number becomes 1, both streams go idle.
//   Stall: the result stays in the output register while m_tready is low; the
//   next input is taken, but its result waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module latency_window_anomaly_monitor (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [31:0] latency_ns, [71:32] now_ns
    input  wire logic [lwam_pkg::IN_DATA_W-1:0]     s_tdata,
    // [0] command
    input  wire logic [lwam_pkg::IN_USER_W-1:0]     s_tuser,
    // master stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [31:0] window_mean_ns, [63:32] baseline_ns, [79:64] packet_count
    output logic      [lwam_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [0] window_closed, [1] alert
    output logic      [lwam_pkg::OUT_USER_W-1:0]    m_tuser,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lwam_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [lwam_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [lwam_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    lwam_pkg::t_cfg    cfg;
    lwam_pkg::t_cmd    cmd;
    lwam_pkg::t_status status;

    logic                            out_closed;
    logic                            out_alert;
    logic [lwam_pkg::MEAN_W-1:0]     out_mean;
    logic [lwam_pkg::BASE_W-1:0]     out_base;
    logic [lwam_pkg::CNT_W-1:0]      out_count;

    lwam_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lwam_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    lwam_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg      (cfg),
        .i_command  (s_tuser[0]),
        .i_latency  (s_tdata[31:0]),
        .i_now      (s_tdata[71:32]),
        .o_closed   (out_closed),
        .o_alert    (out_alert),
        .o_mean     (out_mean),
        .o_baseline (out_base),
        .o_count    (out_count)
    );

    assign m_tdata = {out_count, out_base, out_mean};
    assign m_tuser = {out_alert, out_closed};

endmodule

`default_nettype wire

// File: tb/tb_latency_window_anomaly_monitor.sv
// Testbench for latency_window_anomaly_monitor: drives packet and clear transfers and
// writes registers over APB, predicts every result and checks it field by field.
// Depends on lwam_pkg and the latency_window_anomaly_monitor RTL.
`timescale 1ns / 1ps

module tb_latency_window_anomaly_monitor;

    localparam int          CLK_HALF     = 10;
    localparam int unsigned CYCLE_LIMIT  = 1200000;
    localparam int          IDLE_PERCENT = 37;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 150;

    typedef enum logic [1:0] {
        ENTRY_PACKET,
        ENTRY_CONFIG,
        ENTRY_DRAIN
    } t_entry_kind;

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_command;

    typedef struct packed {
        t_entry_kind                   kind;
        t_command                      command;
        logic [lwam_pkg::LAT_IN_W-1:0] latency;
        logic [lwam_pkg::TIME_W-1:0]   now;
        lwam_pkg::t_reg_idx            reg_sel;
        logic [63:0]                   value;
        logic                          calm;
    } t_monitor_event;

    typedef struct packed {
        logic                        closed;
        logic                        alert;
        logic [lwam_pkg::MEAN_W-1:0] mean;
        logic [lwam_pkg::BASE_W-1:0] baseline;
        logic [lwam_pkg::CNT_W-1:0]  count;
    } t_window_result;

    logic                            i_clk    = 1'b0;
    logic                            i_rst_n  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lwam_pkg::IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] latency_ns, [71:32] now_ns
    logic [lwam_pkg::IN_USER_W-1:0]  s_tuser  = '0;   // [0] command
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lwam_pkg::OUT_DATA_W-1:0] m_tdata;  // [31:0] mean, [63:32] baseline, [79:64] count
    logic [lwam_pkg::OUT_USER_W-1:0] m_tuser;  // [0] window_closed, [1] alert
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [lwam_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [lwam_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [lwam_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    latency_window_anomaly_monitor i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // window state and registers as the block should hold them
    logic [lwam_pkg::CNT_W-1:0]    cfg_wsize;
    logic [lwam_pkg::THR_W-1:0]    cfg_thr;
    logic [lwam_pkg::TIME_W-1:0]   cfg_timeout;
    logic [lwam_pkg::SUM_BITS-1:0] win_sum;
    logic [lwam_pkg::CNT_W-1:0]    win_packets;
    logic [lwam_pkg::WNUM_W-1:0]   win_number;
    logic [lwam_pkg::BASE_W-1:0]   baseline_avg;
    logic [lwam_pkg::TIME_W-1:0]   last_check_ns;
    logic                          check_seen;

    t_monitor_event              event_q[$];
    t_window_result              expected_results[$];
    logic [lwam_pkg::TIME_W-1:0] clock_ns = '0;
    logic                        calm_mode = 1'b0;
    logic                        quiet = 1'b0;
    int unsigned                 errors = 0;
    int unsigned                 cycle_count = 0;
    int unsigned                 events_taken = 0;
    int unsigned                 results_seen = 0;

    function automatic t_window_result step_window(input t_monitor_event ev);
        t_window_result r;
        logic [63:0] sum_max;
        logic [63:0] sum64;
        logic [63:0] lat64;
        logic [63:0] n64;
        logic [63:0] mean64;
        logic [63:0] base64;
        logic        timed_out;
        r = '0;
        sum_max = {64{1'b1}} >> (64 - lwam_pkg::SUM_BITS);
        if (ev.command == CMD_CLEAR) begin
            win_sum      = '0;
            win_packets  = '0;
            win_number   = lwam_pkg::WNUM_W'(1);
            baseline_avg = '0;
        end else begin
            lat64 = {32'd0, ev.latency} & ({64{1'b1}} >> (64 - lwam_pkg::LATENCY_BITS));
            sum64 = 64'(win_sum);
            if (sum64 > sum_max - lat64) begin
                sum64 = sum_max;
            end else begin
                sum64 = sum64 + lat64;
            end
            win_sum = sum64[lwam_pkg::SUM_BITS-1:0];
            if (win_packets != {lwam_pkg::CNT_W{1'b1}}) begin
                win_packets = win_packets + 1'b1;
            end
            timed_out = check_seen && (ev.now >= last_check_ns) &&
                        ((ev.now - last_check_ns) > cfg_timeout);
            if (win_packets >= cfg_wsize || timed_out) begin
                r.closed      = 1'b1;
                last_check_ns = ev.now;
                check_seen    = 1'b1;
                n64           = 64'(win_number);
                base64        = 64'(baseline_avg);
                mean64        = sum64 / 64'(win_packets);
                if (mean64 > 64'hFFFF_FFFF) begin
                    mean64 = 64'hFFFF_FFFF;
                end
                if ((mean64 << 8) > ({48'd0, cfg_thr} * base64) && n64 > 64'd2) begin
                    r.alert = 1'b1;
                end else begin
                    if (n64 == 64'd0) begin
                        n64 = 64'd1;
                    end
                    base64 = ((n64 - 64'd1) * base64 + mean64) / n64;
                    baseline_avg = base64[lwam_pkg::BASE_W-1:0];
                    if (win_number != {lwam_pkg::WNUM_W{1'b1}}) begin
                        win_number = win_number + 1'b1;
                    end
                end
                r.mean      = mean64[lwam_pkg::MEAN_W-1:0];
                win_sum     = '0;
                win_packets = '0;
            end
        end
        r.baseline = baseline_avg;
        r.count    = win_packets;
        return r;
    endfunction

    task automatic add_packet(input logic [lwam_pkg::LAT_IN_W-1:0] lat,
                              input logic [lwam_pkg::TIME_W-1:0] now);
        t_monitor_event ev;
        ev = '0;
        ev.kind    = ENTRY_PACKET;
        ev.command = CMD_PACKET;
        ev.latency = lat;
        ev.now     = now;
        ev.calm    = calm_mode;
        event_q.push_back(ev);
    endtask

    task automatic add_clear();
        t_monitor_event ev;
        logic [63:0]    junk;
        ev = '0;
        junk = {$urandom, $urandom};
        ev.kind    = ENTRY_PACKET;
        ev.command = CMD_CLEAR;
        ev.latency = $urandom;
        ev.now     = junk[lwam_pkg::TIME_W-1:0];
        ev.calm    = calm_mode;
        event_q.push_back(ev);
    endtask

    task automatic add_config(input lwam_pkg::t_reg_idx sel, input logic [63:0] value);
        t_monitor_event ev;
        ev = '0;
        ev.kind    = ENTRY_CONFIG;
        ev.reg_sel = sel;
        ev.value   = value;
        event_q.push_back(ev);
    endtask

    task automatic add_drain();
        t_monitor_event ev;
        ev = '0;
        ev.kind = ENTRY_DRAIN;
        event_q.push_back(ev);
    endtask

    // mostly steady latencies around a base, with spikes, wild values and clears
    task automatic add_random_phase(input int count, input logic [31:0] base, input int step);
        logic [31:0] lat;
        logic [63:0] wide;
        int          pick;
        int unsigned back;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                add_clear();
            end else begin
                if (pick < 70) begin
                    lat = base + $urandom_range(0, base / 4);
                end else if (pick < 82) begin
                    lat = base * $urandom_range(2, 6);
                end else if (pick < 92) begin
                    lat = $urandom_range(0, base);
                end else if (pick < 97) begin
                    lat = $urandom;
                end else begin
                    lat = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
                end
                pick = $urandom_range(99);
                if (pick < 3) begin
                    back = $urandom_range(0, step * 4);
                    clock_ns = (clock_ns > lwam_pkg::TIME_W'(back)) ?
                               clock_ns - lwam_pkg::TIME_W'(back) : '0;
                end else if (pick < 5) begin
                    wide = {$urandom, $urandom};
                    clock_ns = wide[lwam_pkg::TIME_W-1:0];
                end else begin
                    clock_ns = clock_ns + lwam_pkg::TIME_W'($urandom_range(0, step));
                end
                add_packet(lat, clock_ns);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // driver: one stream transfer or one APB write at a time
    logic               tx_valid;
    t_monitor_event     tx_event;
    t_monitor_event     head_event;
    lwam_pkg::t_reg_idx apb_reg;
    logic [63:0]        apb_value;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            tx_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(step_window(tx_event));
                events_taken++;
                tx_valid = 1'b0;
            end
            if (psel && penable && pready) begin
                case (apb_reg)
                    lwam_pkg::REG_WINDOW_SIZE: cfg_wsize   = apb_value[lwam_pkg::CNT_W-1:0];
                    lwam_pkg::REG_THRESHOLD:   cfg_thr     = apb_value[lwam_pkg::THR_W-1:0];
                    lwam_pkg::REG_TIMEOUT:     cfg_timeout = apb_value[lwam_pkg::TIME_W-1:0];
                    default: ;
                endcase
                psel    <= 1'b0;
                penable <= 1'b0;
                pwrite  <= 1'b0;
            end else if (psel) begin
                penable <= 1'b1;
            end else if (!tx_valid && event_q.size() != 0) begin
                head_event = event_q[0];
                case (head_event.kind)
                    ENTRY_DRAIN: begin
                        if (events_taken == results_seen) begin
                            head_event = event_q.pop_front();
                        end
                    end
                    ENTRY_CONFIG: begin
                        if (events_taken == results_seen) begin
                            head_event = event_q.pop_front();
                            apb_reg    = head_event.reg_sel;
                            apb_value  = head_event.value;
                            psel   <= 1'b1;
                            pwrite <= 1'b1;
                            paddr  <= {head_event.reg_sel, 3'b000};
                            pwdata <= head_event.value;
                        end
                    end
                    default: begin
                        quiet <= head_event.calm;
                        if (head_event.calm || $urandom_range(99) >= IDLE_PERCENT) begin
                            tx_event = event_q.pop_front();
                            tx_valid = 1'b1;
                            s_tdata <= {tx_event.now, tx_event.latency};
                            s_tuser <= tx_event.command;
                        end
                    end
                endcase
            end
            s_tvalid <= tx_valid;
        end
    end

    // monitor: check each result transfer, stall at random, hold off twice
    t_window_result want_result;
    logic           rx_ready;
    int unsigned    rx_count = 0;
    int unsigned    hold_left = 0;
    int unsigned    last_hold_mark = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    errors++;
                end else begin
                    want_result = expected_results.pop_front();
                    check_field("window_closed", 64'(want_result.closed), 64'(m_tuser[0]));
                    check_field("alert", 64'(want_result.alert), 64'(m_tuser[1]));
                    check_field("window_mean_ns", 64'(want_result.mean), 64'(m_tdata[31:0]));
                    check_field("baseline_ns", 64'(want_result.baseline),
                                64'(m_tdata[63:32]));
                    check_field("packet_count", 64'(want_result.count), 64'(m_tdata[79:64]));
                end
                rx_count++;
                results_seen <= rx_count;
            end
            if (hold_left != 0) begin
                hold_left--;
                rx_ready = 1'b0;
            end else if ((rx_count == 400 || rx_count == 1300) && rx_count != last_hold_mark) begin
                hold_left      = HOLD_CYCLES;
                last_hold_mark = rx_count;
                rx_ready       = 1'b0;
            end else begin
                rx_ready = quiet || ($urandom_range(99) >= IDLE_PERCENT);
            end
            m_tready <= rx_ready;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        cfg_wsize     = lwam_pkg::WSIZE_RESET;
        cfg_thr       = lwam_pkg::THR_RESET;
        cfg_timeout   = lwam_pkg::TIMEOUT_RESET;
        win_sum       = '0;
        win_packets   = '0;
        win_number    = lwam_pkg::WNUM_W'(1);
        baseline_avg  = '0;
        last_check_ns = '0;
        check_seen    = 1'b0;

        // window of three, bounds of latency and time, clear
        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd3);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd512);
        add_config(lwam_pkg::REG_TIMEOUT, 64'hFF_FFFF_FFFF);
        add_packet(32'd0, 40'd0);
        add_packet(32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        add_packet(32'd100, 40'd5);
        add_clear();
        // baseline, alert on third window, then fold
        for (int w = 0; w < 4; w++) begin
            for (int p = 0; p < 3; p++) begin
                add_packet((w == 2) ? 32'd50 : (w == 3) ? 32'd15 : 32'd10, 40'd100);
            end
        end
        // timeout close, no close with time going backwards
        add_config(lwam_pkg::REG_TIMEOUT, 64'd1);
        add_packet(32'd20, 40'd101);
        add_packet(32'd20, 40'd103);
        add_packet(32'd30, 40'd50);
        // every packet closes with zero window size
        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd0);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd0);
        add_packet(32'd5, 40'd60);
        add_packet(32'd0, 40'd61);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd65535);
        add_packet(32'hFFFF_FFFF, 40'd62);
        add_clear();

        clock_ns = 40'd1000;
        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd4);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd384);
        add_config(lwam_pkg::REG_TIMEOUT, 64'd1000000);
        add_random_phase(350, 32'd1000, 2000);

        calm_mode = 1'b1;
        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd1);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd65535);
        add_config(lwam_pkg::REG_TIMEOUT, 64'hFF_FFFF_FFFF);
        add_random_phase(250, 32'd700, 500);
        calm_mode = 1'b0;

        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'($urandom_range(2, 12)));
        add_config(lwam_pkg::REG_THRESHOLD, 64'($urandom_range(0, 65535)));
        add_config(lwam_pkg::REG_TIMEOUT, 64'd300);
        add_random_phase(200, 32'd5000, 200);
        add_drain();
        add_random_phase(200, 32'd5000, 200);

        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd65535);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd512);
        add_config(lwam_pkg::REG_TIMEOUT, 64'($urandom_range(500, 3000)));
        add_random_phase(300, 32'd20000, 400);

        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'($urandom_range(1, 6)));
        add_config(lwam_pkg::REG_THRESHOLD, 64'd256);
        add_config(lwam_pkg::REG_TIMEOUT, {24'd0, 8'($urandom_range(0, 255)), $urandom});
        add_random_phase(250, 32'd300000, 100000);

        add_config(lwam_pkg::REG_WINDOW_SIZE, 64'd2);
        add_config(lwam_pkg::REG_THRESHOLD, 64'd0);
        add_config(lwam_pkg::REG_TIMEOUT, 64'd1);
        add_random_phase(250, 32'd50, 3);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (event_q.size() != 0 || s_tvalid || psel || events_taken != results_seen) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lwam_pkg.sv
hw/rtl/lwam_regs.sv
hw/rtl/lwam_ctrl.sv
hw/rtl/lwam_dpath.sv
hw/rtl/latency_window_anomaly_monitor.sv
tb/tb_latency_window_anomaly_monitor.sv
